>>> sv/pu4x8_pkg.sv
`timescale 1ns / 1ps
package pu4x8_pkg;

    localparam int unsigned FW = 32;
    localparam int unsigned BW = 8;
    localparam int unsigned NCOMP = 4;

    localparam logic FUNC_PACK   = 1'b0;
    localparam logic FUNC_UNPACK = 1'b1;

    localparam logic [FW-1:0] ONE_BITS = 32'h3F80_0000;
    // single-precision 1/255
    localparam logic [FW-1:0] RECIP_BITS = 32'h3B80_8081;
    localparam logic [FW-1:0] SCALE_BITS = 32'h437F_0000;

    // unpack result per byte, precomputed as float bits of byte * (1/255)
    // each entry is rne(b * recip) where recip mantissa = 0x808081, exp -8
    function automatic logic [FW-1:0] unpack_byte(input logic [BW-1:0] b);
        logic [31:0] prod;
        logic [4:0]  lz;
        logic        found;
        logic [31:0] norm;
        logic [7:0]  expo;
        logic [23:0] mant;
        logic        rnd;
        logic        stk;
        logic [24:0] mr;
        begin
            prod = 32'(b) * 32'h0080_8081;
            lz = 5'd0;
            found = 1'b0;
            for (int i = 31; i >= 0; i--)
            begin
                if (prod[i] && !found)
                begin
                    lz = 5'(31 - i);
                    found = 1'b1;
                end
            end
            norm = prod << lz;
            // value = prod * 2^-31 ; top bit at 31-lz => exponent 31-lz-31 = -lz
            mant = norm[31:8];
            rnd = norm[7];
            stk = |norm[6:0];
            mr = {1'b0, mant} + 25'((rnd && (stk || mant[0])) ? 1 : 0);
            expo = 8'(127 - 32'(lz));
            if (mr[24])
            begin
                expo = expo + 8'd1;
                mr = mr >> 1;
            end
            if (b == '0)
            begin
                unpack_byte = '0;
            end
            else
            begin
                unpack_byte = {1'b0, expo, mr[22:0]};
            end
        end
    endfunction

endpackage

>>> sv/pu4x8_lane.sv
`timescale 1ns / 1ps
module pu4x8_lane (
    input  logic                   clk,
    input  logic                   en0,
    input  logic                   en1,
    input  logic                   en2,
    input  logic [pu4x8_pkg::FW-1:0] comp,
    input  logic [pu4x8_pkg::BW-1:0] byte_in,
    output logic [pu4x8_pkg::BW-1:0] byte_out,
    output logic [pu4x8_pkg::FW-1:0] flt_out
);
    import pu4x8_pkg::*;

    // stage 1: clamp, 24-bit significand and shift amount
    logic [23:0] sig_reg, sig_next;
    logic [4:0]  sh_reg, sh_next;
    logic        sat_reg, sat_next, zero_reg, zero_next;
    logic [BW-1:0] b1_reg;

    always_comb
    begin
        sig_next  = {1'b1, comp[22:0]};
        sh_next   = 5'd0;
        sat_next  = 1'b0;
        zero_next = 1'b0;
        if (comp[31] || (comp[30:23] == 8'hFF && comp[22:0] != '0) || comp[30:23] < 8'd102)
        begin
            zero_next = 1'b1;
        end
        else if (comp[30:0] >= ONE_BITS[30:0])
        begin
            sat_next = 1'b1;
        end
        else
        begin
            // value = sig * 2^(e-150), e in [102,126]
            sh_next = 5'(8'd126 - comp[30:23]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            sig_reg  <= sig_next;
            sh_reg   <= sh_next;
            sat_reg  <= sat_next;
            zero_reg <= zero_next;
            b1_reg   <= byte_in;
        end
    end

    // stage 2: multiply by 255 (exact 32-bit product), unpack the byte
    logic [31:0] prod_reg, prod_next;
    logic [4:0]  sh2_reg;
    logic        sat2_reg, zero2_reg;
    logic [FW-1:0] f2_reg;

    assign prod_next = {8'd0, sig_reg} * 32'd255;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg  <= prod_next;
            sh2_reg   <= sh_reg;
            sat2_reg  <= sat_reg;
            zero2_reg <= zero_reg;
            f2_reg    <= unpack_byte(b1_reg);
        end
    end

    // stage 3: float rne to 24 bits, then round half up to integer
    // product value = prod * 2^(-24-sh) ; sh 0 => value < 255
    logic [BW-1:0] q_next;
    logic [55:0]   ext;
    logic [55:0]   shv;
    logic [55:0]   fr;
    logic          top;
    logic [31:0]   pr;
    logic [7:0]    ip;

    always_comb
    begin
        // rne of prod to 24 significant bits; prod has 31 or 32 bits
        top = prod_reg[31];
        if (top)
        begin
            pr = {prod_reg[31:8], 8'd0} +
                 ((prod_reg[7] && ((|prod_reg[6:0]) || prod_reg[8])) ? 32'h100 : 32'h0);
        end
        else
        begin
            pr = {prod_reg[31:7], 7'd0} +
                 ((prod_reg[6] && ((|prod_reg[5:0]) || prod_reg[7])) ? 32'h80 : 32'h0);
        end
        // integer part is pr >> (24+sh), fraction bit just below
        ext = {pr, 24'd0};
        shv = ext >> (7'd48 + 7'(sh2_reg));
        ip  = shv[7:0];
        fr  = ext >> (7'd47 + 7'(sh2_reg));
        if (zero2_reg)
        begin
            q_next = '0;
        end
        else if (sat2_reg)
        begin
            q_next = 8'hFF;
        end
        else
        begin
            q_next = ip + {7'd0, fr[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            byte_out <= q_next;
            flt_out  <= f2_reg;
        end
    end

endmodule

>>> sv/pack_unpack_unorm_4x8_top.sv
`timescale 1ns / 1ps
// glsl packUnorm4x8 / unpackUnorm4x8 converter. func 0 packs four single
// floats (clamped to [0,1], NaN to 0) into bytes, func 1 unpacks a word into
// four floats byte*(1/255). one request per cycle while the output is not
// stalled, through a stall-able three-stage pipeline (clamp, multiply by
// 255, round); the unused output fields read zero.
module pack_unpack_unorm_4x8_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] comp0_in,
    input  logic [31:0] comp1_in,
    input  logic [31:0] comp2_in,
    input  logic [31:0] comp3_in,
    input  logic [31:0] word_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] word_out,
    output logic [31:0] comp0_out,
    output logic [31:0] comp1_out,
    output logic [31:0] comp2_out,
    output logic [31:0] comp3_out
);
    import pu4x8_pkg::*;

    logic v0_reg, v1_reg, v2_reg;
    logic f0_reg, f1_reg, f2_reg;
    logic en0, en1, en2;

    assign en2 = !v2_reg || !out_stall;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign in_stall = !en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= in_valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0) f0_reg <= func;
        if (en1) f1_reg <= f0_reg;
        if (en2) f2_reg <= f1_reg;
    end

    logic [FW-1:0] comps [NCOMP];
    logic [BW-1:0] bytes_o [NCOMP];
    logic [FW-1:0] flts [NCOMP];

    assign comps[0] = comp0_in;
    assign comps[1] = comp1_in;
    assign comps[2] = comp2_in;
    assign comps[3] = comp3_in;

    for (genvar k = 0; k < NCOMP; k++)
    begin : g_lane
        pu4x8_lane u_lane (
            .clk      (clk),
            .en0      (en0),
            .en1      (en1),
            .en2      (en2),
            .comp     (comps[k]),
            .byte_in  (word_in[BW*k +: BW]),
            .byte_out (bytes_o[k]),
            .flt_out  (flts[k])
        );
    end

    logic is_pack;
    assign is_pack   = (f2_reg == FUNC_PACK);
    assign out_valid = v2_reg;
    assign word_out  = is_pack ? {bytes_o[3], bytes_o[2], bytes_o[1], bytes_o[0]} : '0;
    assign comp0_out = is_pack ? '0 : flts[0];
    assign comp1_out = is_pack ? '0 : flts[1];
    assign comp2_out = is_pack ? '0 : flts[2];
    assign comp3_out = is_pack ? '0 : flts[3];

`ifndef SYNTHESIS
    a_no_in_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall) else $error("stall without backpressure");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_out))
        else $error("result changed under stall");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (word_out == '0) || (comp0_out == '0 && comp3_out == '0))
        else $error("both result groups set");
`endif

endmodule

>>> tb/sv/pack_unpack_unorm_4x8_top_test.sv
`timescale 1ns / 1ps
module pack_unpack_unorm_4x8_top_test;
    import pu4x8_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [31:0] comp [4];
    } conv_result_t;

    class conv_scoreboard;
        conv_result_t pending [$];
        int           errors;

        // round a positive integer to a 24-bit significand, nearest even;
        // the value becomes sig * 2^shift
        static function automatic void round_sig24(input logic [63:0] p,
                                                   output logic [63:0] sig,
                                                   output int shift);
            int   n;
            logic guard;
            logic sticky;
            n = 63;
            while (!p[n])
            begin
                n--;
            end
            if (n > 23)
            begin
                shift = n - 23;
                sig = p >> shift;
                guard = p[shift-1];
                sticky = (p & ((64'd1 << (shift - 1)) - 64'd1)) != 64'd0;
                if (guard && (sticky || sig[0]))
                begin
                    sig = sig + 64'd1;
                end
                if (sig[24])
                begin
                    sig = sig >> 1;
                    shift++;
                end
            end
            else
            begin
                shift = n - 23;
                sig = p << (23 - n);
            end
        endfunction

        static function automatic logic [7:0] to_unorm8(input logic [31:0] f);
            logic [7:0]  ex;
            logic [63:0] sig;
            int          shift;
            int          t;
            logic [63:0] whole;
            ex = f[30:23];
            if (ex == 8'hFF && f[22:0] != 0)
            begin
                return 8'd0;
            end
            if (f[31] || ex == 8'd0)
            begin
                return 8'd0;
            end
            if (ex >= 8'd127)
            begin
                return 8'd255;
            end
            round_sig24(64'({1'b1, f[22:0]}) * 64'd255, sig, shift);
            t = 23 - shift - (int'(ex) - 127);
            if (t >= 40)
            begin
                return 8'd0;
            end
            whole = (sig >> t) + 64'(sig[t-1]);
            return whole[7:0];
        endfunction

        static function automatic logic [31:0] from_unorm8(input logic [7:0] b);
            logic [63:0] sig;
            int          shift;
            logic [7:0]  ex;
            if (b == 8'd0)
            begin
                return 32'd0;
            end
            // 1/255 in single precision is 0x808081 * 2^-31
            round_sig24(64'(b) * 64'h80_8081, sig, shift);
            ex = 8'(shift + 119);
            return {1'b0, ex, sig[22:0]};
        endfunction

        function void note(input logic fn, input logic [31:0] c [4],
                           input logic [31:0] w);
            conv_result_t r;
            r.word = 32'd0;
            for (int k = 0; k < 4; k++)
            begin
                r.comp[k] = 32'd0;
            end
            for (int k = 0; k < 4; k++)
            begin
                if (fn == FUNC_PACK)
                begin
                    r.word[8*k +: 8] = to_unorm8(c[k]);
                end
                else
                begin
                    r.comp[k] = from_unorm8(w[8*k +: 8]);
                end
            end
            pending.push_back(r);
        endfunction

        function void check(input logic [31:0] w, input logic [31:0] c [4]);
            conv_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w !== e.word)
            begin
                $display("%0t: word_out expected %h actual %h", $time, e.word, w);
                errors++;
            end
            for (int k = 0; k < 4; k++)
            begin
                if (c[k] !== e.comp[k])
                begin
                    $display("%0t: comp%0d_out expected %h actual %h",
                             $time, k, e.comp[k], c[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [31:0] comp0_in;
    logic [31:0] comp1_in;
    logic [31:0] comp2_in;
    logic [31:0] comp3_in;
    logic [31:0] word_in;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] word_out;
    logic [31:0] comp0_out;
    logic [31:0] comp1_out;
    logic [31:0] comp2_out;
    logic [31:0] comp3_out;

    conv_scoreboard sb;
    bit             no_gaps;
    bit             long_hold;
    int             quiet_cycles;

    pack_unpack_unorm_4x8_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .comp0_in  (comp0_in),
        .comp1_in  (comp1_in),
        .comp2_in  (comp2_in),
        .comp3_in  (comp3_in),
        .word_in   (word_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word_out  (word_out),
        .comp0_out (comp0_out),
        .comp1_out (comp1_out),
        .comp2_out (comp2_out),
        .comp3_out (comp3_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_request(input logic fn, input logic [31:0] c0,
                                input logic [31:0] c1, input logic [31:0] c2,
                                input logic [31:0] c3, input logic [31:0] w);
        logic [31:0] c [4];
        int          gap;
        c = '{c0, c1, c2, c3};
        in_valid <= 1'b1;
        func <= fn;
        comp0_in <= c0;
        comp1_in <= c1;
        comp2_in <= c2;
        comp3_in <= c3;
        word_in <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note(fn, c, w);
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // float in [0,1) with a random significand, or exactly one
    function automatic logic [31:0] unit_float();
        if ($urandom_range(0, 15) == 0)
        begin
            return ONE_BITS;
        end
        return {1'b0, 8'($urandom_range(112, 126)), 23'($urandom)};
    endfunction

    function automatic logic [31:0] any_comp();
        return ($urandom_range(0, 3) == 0) ? 32'($urandom) : unit_float();
    endfunction

    always @(posedge clk)
    begin
        logic [31:0] c [4];
        if (out_valid && !out_stall)
        begin
            c = '{comp0_out, comp1_out, comp2_out, comp3_out};
            sb.check(word_out, c);
        end
    end

    // result side: random stall before each result, one long hold-off
    initial
    begin
        int k;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                k = 300;
                long_hold = 1'b0;
            end
            else
            begin
                k = no_gaps ? 0 : $urandom_range(0, 10);
            end
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 2000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] c [4];
        sb = new();
        no_gaps = 1'b0;
        long_hold = 1'b0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_PACK;
        comp0_in = 32'd0;
        comp1_in = 32'd0;
        comp2_in = 32'd0;
        comp3_in = 32'd0;
        word_in = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, one, negative zero, minus one
        send_request(FUNC_PACK, 32'h0, ONE_BITS, 32'h8000_0000, 32'hBF80_0000, 32'h0);
        // nan, +inf, -inf, two
        send_request(FUNC_PACK, 32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h4000_0000, 32'hFFFF_FFFF);
        // exact half after scaling, denormal, max float, negative nan
        send_request(FUNC_PACK, 32'h3F00_0000, 32'h0000_0001, 32'h7F7F_FFFF,
                     32'hFFFF_FFFF, 32'h0);
        // near one, 1/255, 0.5/255, 1.5/255
        send_request(FUNC_PACK, 32'h3F7F_FFFF, RECIP_BITS, 32'h3B00_8081,
                     32'h3BC0_C0C1, 32'h0);
        send_request(FUNC_PACK, 32'h0080_0000, 32'h3EFF_FFFF, 32'h3F00_0001,
                     32'h8000_0001, 32'h0);
        send_request(FUNC_UNPACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_request(FUNC_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0403_0201);
        send_request(FUNC_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8080_7F7F);
        send_request(FUNC_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFE55_AA01);
        for (int i = 0; i < 8; i++)
        begin
            send_request(FUNC_PACK, 32'h3C00_0000 + 32'(i) * 32'h0080_0000, 32'h0,
                         32'h0, 32'h0, 32'h0);
        end

        for (int i = 0; i < 1000; i++)
        begin
            if (i % 100 == 0)
            begin
                no_gaps = (i % 300 == 200);
            end
            if (i == 400)
            begin
                long_hold = 1'b1;
            end
            send_request(logic'($urandom_range(0, 1)), any_comp(), any_comp(),
                         any_comp(), any_comp(), 32'($urandom));
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> sim.f
sv/pu4x8_pkg.sv
sv/pu4x8_lane.sv
sv/pack_unpack_unorm_4x8_top.sv
tb/sv/pack_unpack_unorm_4x8_top_test.sv
